FILE: src/iaid_pkg.sv
// Package for the indexed array insert/delete block: sizes, codes and handshake structs.
`timescale 1ns / 1ps

package iaid_pkg;

  // List storage
  localparam int CAPACITY = 16;
  localparam int AW       = $clog2(CAPACITY);

  // Field widths
  localparam int OP_W    = 2;
  localparam int POS_W   = 5;
  localparam int VAL_W   = 32;
  localparam int ST_W    = 2;
  localparam int CNT_W   = 5;

  // Stream payload widths (fields packed from bit 0, padded to whole bytes)
  localparam int IN_TDATA_W  = ((POS_W + VAL_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((VAL_W + CNT_W + 7) / 8) * 8;

  // Operation codes
  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
  localparam logic [OP_W-1:0] OP_READ   = 2'd2;

  // Status codes
  localparam logic [ST_W-1:0] ST_DONE  = 2'd0;
  localparam logic [ST_W-1:0] ST_RANGE = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

  // Controller to datapath commands
  typedef struct packed {
    logic load;      // latch an input beat
    logic check;     // latch the range/full verdict
    logic ins_init;  // set up the upward shift
    logic del_init;  // set up the downward shift
    logic ins_step;  // one insert shift step
    logic del_step;  // one delete shift step
    logic rd_issue;  // read the addressed entry
    logic finish;    // load the result register
  } iaid_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic [OP_W-1:0] op;    // latched operation
    logic [ST_W-1:0] chk;   // verdict for the latched operation
    logic            last;  // current shift step is the final one
  } iaid_sts_t;

endpackage

FILE: src/iaid_dp.sv
// Datapath: entry memory, fill count, shift cursor and result register.
`timescale 1ns / 1ps

module iaid_dp (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  iaid_pkg::iaid_cmd_t       cmd_i,
  output iaid_pkg::iaid_sts_t       sts_o,
  input  logic [iaid_pkg::OP_W-1:0]  in_op_i,
  input  logic [iaid_pkg::POS_W-1:0] in_pos_i,
  input  logic signed [iaid_pkg::VAL_W-1:0] in_value_i,
  output logic [iaid_pkg::ST_W-1:0]  out_status_o,
  output logic signed [iaid_pkg::VAL_W-1:0] out_read_value_o,
  output logic [iaid_pkg::CNT_W-1:0] out_count_o
);
  import iaid_pkg::*;

  // Latched operation
  logic [OP_W-1:0]  op_q;
  logic [POS_W-1:0] pos_q;
  logic [VAL_W-1:0] val_q;
  logic [ST_W-1:0]  st_q;
  logic [ST_W-1:0]  chk;

  // Shift control
  logic [CNT_W-1:0] fill_q, fill_d;
  logic [CNT_W-1:0] cur_q, cur_d;
  logic [CNT_W-1:0] cur_dec;
  logic [AW-1:0]    wa_q, wa_d;
  logic             pend_q, pend_d;
  logic             last;

  // Memory ports
  logic [VAL_W-1:0] mem [CAPACITY];
  logic             wr_en;
  logic [AW-1:0]    wr_addr;
  logic [VAL_W-1:0] wr_data;
  logic             rd_en;
  logic [AW-1:0]    rd_addr;
  logic [VAL_W-1:0] rdata_q;

  // Result register
  logic [ST_W-1:0]  out_status_q;
  logic [VAL_W-1:0] out_rdval_q;
  logic [CNT_W-1:0] out_count_q;

  // Verdict: insert checks range before fullness
  always_comb begin
    case (op_q)
      OP_INSERT: begin
        if (pos_q > fill_q) begin
          chk = ST_RANGE;
        end else if (fill_q >= CNT_W'(CAPACITY)) begin
          chk = ST_FULL;
        end else begin
          chk = ST_DONE;
        end
      end
      OP_DELETE, OP_READ: begin
        chk = (pos_q < fill_q) ? ST_DONE : ST_RANGE;
      end
      default: begin
        chk = ST_RANGE;
      end
    endcase
  end

  assign cur_dec = cur_q - CNT_W'(1);

  // Final shift step: nothing left to move and no write in flight
  assign last = !pend_q && ((op_q == OP_DELETE) ? (cur_q >= fill_q) : (cur_q <= pos_q));

  // Shift sequencing: a read issued one cycle is written back the next
  always_comb begin
    cur_d   = cur_q;
    wa_d    = wa_q;
    pend_d  = pend_q;
    fill_d  = fill_q;
    wr_en   = 1'b0;
    wr_addr = wa_q;
    wr_data = rdata_q;
    rd_en   = 1'b0;
    rd_addr = pos_q[AW-1:0];

    if (cmd_i.ins_init) begin
      cur_d  = fill_q;
      pend_d = 1'b0;
    end
    if (cmd_i.del_init) begin
      cur_d  = pos_q + CNT_W'(1);
      pend_d = 1'b0;
    end
    if (cmd_i.rd_issue) begin
      rd_en = 1'b1;
    end

    // Insert: entries move up, from the top down to the position
    if (cmd_i.ins_step) begin
      if (pend_q) begin
        wr_en = 1'b1;
      end
      if (cur_q > pos_q) begin
        rd_en   = 1'b1;
        rd_addr = cur_dec[AW-1:0];
        wa_d    = cur_q[AW-1:0];
        pend_d  = 1'b1;
        cur_d   = cur_dec;
      end else begin
        pend_d = 1'b0;
        if (!pend_q) begin
          wr_en   = 1'b1;
          wr_addr = pos_q[AW-1:0];
          wr_data = val_q;
          fill_d  = fill_q + CNT_W'(1);
        end
      end
    end

    // Delete: entries move down, from above the position to the top
    if (cmd_i.del_step) begin
      if (pend_q) begin
        wr_en = 1'b1;
      end
      if (cur_q < fill_q) begin
        rd_en   = 1'b1;
        rd_addr = cur_q[AW-1:0];
        wa_d    = cur_dec[AW-1:0];
        pend_d  = 1'b1;
        cur_d   = cur_q + CNT_W'(1);
      end else begin
        pend_d = 1'b0;
        if (!pend_q) begin
          fill_d = fill_q - CNT_W'(1);
        end
      end
    end
  end

  // Entry memory
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rdata_q <= mem[rd_addr];
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      cur_q  <= '0;
      pend_q <= 1'b0;
    end else begin
      fill_q <= fill_d;
      cur_q  <= cur_d;
      pend_q <= pend_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    wa_q <= wa_d;
    if (cmd_i.load) begin
      op_q  <= in_op_i;
      pos_q <= in_pos_i;
      val_q <= in_value_i;
    end
    if (cmd_i.check) begin
      st_q <= chk;
    end
    if (cmd_i.finish) begin
      out_status_q <= st_q;
      out_rdval_q  <= ((op_q == OP_READ) && (st_q == ST_DONE)) ? rdata_q : '0;
      out_count_q  <= fill_q;
    end
  end

  assign sts_o.op   = op_q;
  assign sts_o.chk  = chk;
  assign sts_o.last = last;

  assign out_status_o     = out_status_q;
  assign out_read_value_o = out_rdval_q;
  assign out_count_o      = out_count_q;

  // Fill never passes capacity
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CNT_W'(CAPACITY))
    else $error("fill count above capacity");

  // Fill moves by at most one per cycle
  a_fill_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> (fill_q == $past(fill_q)) || (fill_q == $past(fill_q) + CNT_W'(1)) ||
             (fill_q == $past(fill_q) - CNT_W'(1)))
    else $error("fill count jumped");

  // No memory write lands while a value is in flight but no shift step is active
  a_no_pend_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pend_q && !cmd_i.ins_step && !cmd_i.del_step) |-> !wr_en)
    else $error("stray memory write");

endmodule

FILE: src/iaid_ctrl.sv
// Controller: sequences check, shift, read and result hand-off for each beat.
`timescale 1ns / 1ps

module iaid_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_valid_i,
  output logic                s_ready_o,
  output logic                m_valid_o,
  input  logic                m_ready_i,
  input  iaid_pkg::iaid_sts_t sts_i,
  output iaid_pkg::iaid_cmd_t cmd_o
);
  import iaid_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_CHECK = 6'b000010,
    S_INS   = 6'b000100,
    S_DEL   = 6'b001000,
    S_READ  = 6'b010000,
    S_DONE  = 6'b100000
  } state_e;

  state_e    state_q, state_d;
  logic      m_valid_q, m_valid_d;
  iaid_cmd_t cmd;

  // Next state and commands
  always_comb begin
    state_d   = state_q;
    cmd       = '0;
    s_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        s_ready_o = 1'b1;
        if (s_valid_i) begin
          cmd.load = 1'b1;
          state_d  = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd.check = 1'b1;
        if (sts_i.chk != ST_DONE) begin
          state_d = S_DONE;
        end else if (sts_i.op == OP_INSERT) begin
          cmd.ins_init = 1'b1;
          state_d      = S_INS;
        end else if (sts_i.op == OP_DELETE) begin
          cmd.del_init = 1'b1;
          state_d      = S_DEL;
        end else begin
          cmd.rd_issue = 1'b1;
          state_d      = S_READ;
        end
      end
      S_INS: begin
        cmd.ins_step = 1'b1;
        if (sts_i.last) begin
          state_d = S_DONE;
        end
      end
      S_DEL: begin
        cmd.del_step = 1'b1;
        if (sts_i.last) begin
          state_d = S_DONE;
        end
      end
      S_READ: begin
        state_d = S_DONE;
      end
      S_DONE: begin
        if (!m_valid_q || m_ready_i) begin
          cmd.finish = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Result valid: set on finish, dropped when the beat is taken
  always_comb begin
    if (cmd.finish) begin
      m_valid_d = 1'b1;
    end else if (m_ready_i) begin
      m_valid_d = 1'b0;
    end else begin
      m_valid_d = m_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      m_valid_q <= m_valid_d;
    end
  end

  assign cmd_o     = cmd;
  assign m_valid_o = m_valid_q;

  // A held result is never overwritten
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_q && !m_ready_i) |-> !cmd.finish)
    else $error("result overwritten before taken");

  // An accepted beat goes straight to the check
  a_accept_check: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_valid_i && s_ready_o) |=> (state_q == S_CHECK))
    else $error("accepted beat not checked");

  // Finishing always presents a result next cycle
  a_finish_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.finish |=> m_valid_q)
    else $error("finished result not presented");

endmodule

FILE: src/indexed_array_insert_delete.sv
// Top level of the indexed array insert/delete block: stream ports, controller, datapath.
//
//  Channel  | Dir | tuser          | tdata (low bit first)
//  ---------+-----+----------------+-----------------------------------------------
//  s_axis   | in  | op [1:0]       | position [4:0], value [36:5], zero [39:37]
//  m_axis   | out | status [1:0]   | read_value [31:0], count [36:32], zero [39:37]
//
// An insert or delete moves m entries, with m = count - position for an insert and
// count - position - 1 for a delete; one entry moves per cycle.
// A beat is taken only in idle, which is entered as the previous result is registered.
// Reset empties the list at once; entries hold whatever was last written.
// A finished result waits in the output register while the next beat is taken;
// the block stalls before finishing only if that register is still full.
`timescale 1ns / 1ps

module indexed_array_insert_delete (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // position [4:0], value [36:5], zero [39:37]
  input  logic [1:0]  s_axis_tuser,   // op [1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // read_value [31:0], count [36:32], zero [39:37]
  output logic [1:0]  m_axis_tuser    // status [1:0]
);
  import iaid_pkg::*;

  iaid_cmd_t               cmd;
  iaid_sts_t               sts;
  logic [ST_W-1:0]         out_status;
  logic signed [VAL_W-1:0] out_read_value;
  logic [CNT_W-1:0]        out_count;

  iaid_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  iaid_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .in_op_i          (s_axis_tuser[OP_W-1:0]),
    .in_pos_i         (s_axis_tdata[POS_W-1:0]),
    .in_value_i       (s_axis_tdata[POS_W+VAL_W-1:POS_W]),
    .out_status_o     (out_status),
    .out_read_value_o (out_read_value),
    .out_count_o      (out_count)
  );

  // Output beat packing
  assign m_axis_tuser = out_status;
  assign m_axis_tdata = {{(OUT_TDATA_W - VAL_W - CNT_W){1'b0}}, out_count, out_read_value};

endmodule
